@@ rtl/cba_pkg.sv @@
// -----------------------------------------------------------------------------
// cba_pkg
// Shared types and codes for the contiguous block allocator: field widths,
// request and result codes, controller states and the command/status bundles
// between controller and datapath.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cba_pkg;

    // beat field widths
    localparam int OP_W   = 2;
    localparam int LEN_W  = 7;
    localparam int BLK_W  = 7;
    localparam int WEND_W = 8;
    localparam int STAT_W = 2;

    // request codes
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_MARK  = 2'd2;

    // result codes
    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOFIT = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    // controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_FILL,
        S_RESP
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic clr_step;
        logic load;
        logic set_scan;
        logic scan_step;
        logic take_hit;
        logic set_fill;
        logic fill_step;
        logic set_nofit;
        logic set_range;
        logic emit;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic is_alloc;
        logic is_fm;
        logic alloc_empty;
        logic range_err;
        logic len_zero;
        logic hit;
        logic scan_end;
        logic fill_last;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

@@ rtl/cba_req_if.sv @@
// -----------------------------------------------------------------------------
// cba_req_if
// Request channel: valid/ready handshake with one allocate, free or mark
// request per beat.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cba_req_if import cba_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [LEN_W-1:0]  run_length;
    logic [BLK_W-1:0]  first_block;
    logic [WEND_W-1:0] window_end;

    modport source (
        output valid, op, run_length, first_block, window_end,
        input  ready
    );

    modport sink (
        input  valid, op, run_length, first_block, window_end,
        output ready
    );

endinterface

`default_nettype wire

@@ rtl/cba_rsp_if.sv @@
// -----------------------------------------------------------------------------
// cba_rsp_if
// Result channel: valid/ready handshake with one status and run start per
// beat.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cba_rsp_if import cba_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [BLK_W-1:0]  run_start;

    modport source (
        output valid, status, run_start,
        input  ready
    );

    modport sink (
        input  valid, status, run_start,
        output ready
    );

endinterface

`default_nettype wire

@@ rtl/contiguous_block_allocator_core.sv @@
// -----------------------------------------------------------------------------
// contiguous_block_allocator_core
// First-fit contiguous allocator over a one-bit-per-block usage map: allocate
// a run inside a window, free a range or mark a range used.
//
//   channel  dir  beat contents                                  handshake
//   i_req    in   op, run_length, first_block, window_end        valid/ready
//   o_rsp    out  status, run_start                              valid/ready
//
// allocate: reads map bits from first_block until the run is found or the window
//           ends, one map bit per cycle from the map RAM
// free/mark: one map bit written per cycle; nothing is written when the range is
//           rejected
// after reset a clearing pass writes every block of the map; i_req is
// not ready during it
// one request in flight; a result held in o_rsp does not block the next request
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module contiguous_block_allocator_core import cba_pkg::*; #(
    parameter int NUM_BLOCKS = 128
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cba_req_if.sink    i_req,
    cba_rsp_if.source  o_rsp
);

    t_dp_cmd cmd;
    t_dp_sts sts;
    t_state  state;

    // sequencing
    cba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_sts      (sts),
        .o_in_ready (i_req.ready),
        .o_cmd      (cmd),
        .o_state    (state)
    );

    // map and registers
    cba_dp #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_op          (i_req.op),
        .i_run_length  (i_req.run_length),
        .i_first_block (i_req.first_block),
        .i_window_end  (i_req.window_end),
        .i_out_ready   (o_rsp.ready),
        .o_out_valid   (o_rsp.valid),
        .o_status      (o_rsp.status),
        .o_run_start   (o_rsp.run_start)
    );

    // an accepted request is decoded in the next cycle
    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (state == S_DECODE))
        else $error("accepted request not decoded");

    // a new result only comes out of the result state
    a_emit_from_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> (state == S_RESP))
        else $error("result emitted outside result state");

    // failed requests report run start zero
    a_fail_start_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status != ST_DONE)) |-> (o_rsp.run_start == '0))
        else $error("failed request with nonzero run start");

    // a found run goes straight to the fill
    a_hit_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.take_hit |=> (state == S_FILL))
        else $error("found run not filled");

endmodule

`default_nettype wire

@@ rtl/cba_ram.sv @@
// -----------------------------------------------------------------------------
// cba_ram
// Generic single-write, single-read RAM with registered read data.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cba_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/cba_ctrl.sv @@
// -----------------------------------------------------------------------------
// cba_ctrl
// Controller of the allocator: sequences the clearing pass, request decode,
// map scan, range fill and result hand-off.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cba_ctrl import cba_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire t_dp_sts i_sts,
    output logic         o_in_ready,
    output t_dp_cmd      o_cmd,
    output t_state       o_state
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                priority if (i_sts.is_alloc) begin
                    n_state = i_sts.alloc_empty ? S_RESP : S_SCAN;
                end else if (i_sts.is_fm) begin
                    n_state = (i_sts.range_err || i_sts.len_zero) ? S_RESP : S_FILL;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_SCAN: begin
                priority if (i_sts.hit) begin
                    n_state = S_FILL;
                end else if (i_sts.scan_end) begin
                    n_state = S_RESP;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_FILL: begin
                if (i_sts.fill_last) n_state = S_RESP;
            end
            S_RESP: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // datapath commands
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_DECODE: begin
                priority if (i_sts.is_alloc) begin
                    o_cmd.set_nofit = i_sts.alloc_empty;
                    o_cmd.set_scan  = !i_sts.alloc_empty;
                end else if (i_sts.is_fm) begin
                    o_cmd.set_range = i_sts.range_err;
                    o_cmd.set_fill  = !i_sts.range_err && !i_sts.len_zero;
                end else begin
                    o_cmd = '0;
                end
            end
            S_SCAN: begin
                priority if (i_sts.hit) begin
                    o_cmd.take_hit = 1'b1;
                end else if (i_sts.scan_end) begin
                    o_cmd.set_nofit = 1'b1;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_FILL: begin
                o_cmd.fill_step = 1'b1;
            end
            S_RESP: begin
                o_cmd.emit = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    assign o_state = r_state;

endmodule

`default_nettype wire

@@ rtl/cba_dp.sv @@
// -----------------------------------------------------------------------------
// cba_dp
// Datapath of the allocator: request registers, the usage map RAM, the scan
// counters, range fill address and the result output register.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cba_dp import cba_pkg::*; #(
    parameter int NUM_BLOCKS = 128
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_dp_cmd           i_cmd,
    output t_dp_sts                o_sts,
    input  wire logic [OP_W-1:0]   i_op,
    input  wire logic [LEN_W-1:0]  i_run_length,
    input  wire logic [BLK_W-1:0]  i_first_block,
    input  wire logic [WEND_W-1:0] i_window_end,
    input  wire logic              i_out_ready,
    output logic                   o_out_valid,
    output logic [STAT_W-1:0]      o_status,
    output logic [BLK_W-1:0]       o_run_start
);

    // block index width, wide enough for the block count and for first + length
    localparam int AW = $clog2(NUM_BLOCKS);
    localparam int CW = ($clog2(NUM_BLOCKS + 1) > WEND_W) ? $clog2(NUM_BLOCKS + 1) : WEND_W;
    localparam logic [CW-1:0] NB      = CW'(NUM_BLOCKS);
    localparam logic [CW-1:0] NB_LAST = CW'(NUM_BLOCKS - 1);

    logic [OP_W-1:0]   r_op;
    logic [LEN_W-1:0]  r_len;
    logic [CW-1:0]     r_first;
    logic [CW-1:0]     r_wend;
    logic [CW-1:0]     r_addr;
    logic [CW-1:0]     r_cmp;
    logic              r_cmp_vld;
    logic [LEN_W-1:0]  r_count;
    logic [LEN_W-1:0]  r_left;
    logic              r_wval;
    logic [STAT_W-1:0] r_res_status;
    logic [BLK_W-1:0]  r_res_start;
    logic              r_out_valid;
    logic [STAT_W-1:0] r_out_status;
    logic [BLK_W-1:0]  r_out_start;

    logic              rd_data;
    logic              rd_en;
    logic              wr_en;
    logic              wr_data;
    logic              addr_in_win;
    logic [LEN_W-1:0]  count_inc;
    logic [CW-1:0]     hit_start;
    logic [CW-1:0]     wend_in;
    logic [CW-1:0]     range_end;

    // usage map, one bit per block
    cba_ram #(
        .WIDTH (1),
        .DEPTH (NUM_BLOCKS)
    ) u_map (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_addr[AW-1:0]),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_addr[AW-1:0]),
        .o_rd_data (rd_data)
    );

    // map access
    assign addr_in_win = r_addr < r_wend;
    assign rd_en       = i_cmd.scan_step && addr_in_win;
    assign wr_en       = i_cmd.clr_step || i_cmd.fill_step;
    assign wr_data     = i_cmd.clr_step ? (r_addr == '0) : r_wval;

    // window end saturated to the map size
    assign wend_in   = (CW'(i_window_end) > NB) ? NB : CW'(i_window_end);
    assign range_end = r_first + CW'(r_len);

    // free-run counting on the block whose read data is back
    assign count_inc = r_count + LEN_W'(1);
    assign hit_start = r_cmp + CW'(1) - CW'(r_len);

    // status to controller
    always_comb begin
        o_sts             = '0;
        o_sts.clr_last    = r_addr == NB_LAST;
        o_sts.is_alloc    = r_op == OP_ALLOC;
        o_sts.is_fm       = (r_op == OP_FREE) || (r_op == OP_MARK);
        o_sts.alloc_empty = (r_len == '0) || (r_first >= r_wend);
        o_sts.range_err   = range_end > NB;
        o_sts.len_zero    = r_len == '0;
        o_sts.hit         = r_cmp_vld && !rd_data && (count_inc == r_len);
        o_sts.scan_end    = !addr_in_win && !r_cmp_vld;
        o_sts.fill_last   = r_left == LEN_W'(1);
        o_sts.out_free    = !r_out_valid || i_out_ready;
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_op;
            r_len   <= i_run_length;
            r_first <= CW'(i_first_block);
            r_wend  <= wend_in;
        end
    end

    // block address: clearing sweep, scan reads and range fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr    <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            priority if (i_cmd.clr_step || i_cmd.fill_step) begin
                r_addr <= r_addr + CW'(1);
            end else if (i_cmd.set_scan || i_cmd.set_fill) begin
                r_addr    <= r_first;
                r_cmp_vld <= 1'b0;
            end else if (i_cmd.take_hit) begin
                r_addr    <= hit_start;
                r_cmp_vld <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_cmp_vld <= addr_in_win;
                if (addr_in_win) begin
                    r_addr <= r_addr + CW'(1);
                end
            end else begin
                r_addr <= r_addr;
            end
        end
    end

    // scan and fill bookkeeping
    always_ff @(posedge i_clk) begin
        if (i_cmd.set_scan) begin
            r_count <= '0;
        end else if (i_cmd.scan_step && r_cmp_vld) begin
            r_count <= rd_data ? '0 : count_inc;
        end
        if (i_cmd.scan_step && addr_in_win) begin
            r_cmp <= r_addr;
        end
        if (i_cmd.set_fill || i_cmd.take_hit) begin
            r_left <= r_len;
            r_wval <= i_cmd.take_hit || (r_op == OP_MARK);
        end else if (i_cmd.fill_step) begin
            r_left <= r_left - LEN_W'(1);
        end
    end

    // pending result
    always_ff @(posedge i_clk) begin
        priority if (i_cmd.load) begin
            r_res_status <= ST_DONE;
            r_res_start  <= '0;
        end else if (i_cmd.set_nofit) begin
            r_res_status <= ST_NOFIT;
        end else if (i_cmd.set_range) begin
            r_res_status <= ST_RANGE;
        end else if (i_cmd.take_hit) begin
            r_res_start <= hit_start[BLK_W-1:0];
        end else begin
            r_res_status <= r_res_status;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_status <= r_res_status;
            r_out_start  <= r_res_start;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_run_start = r_out_start;

endmodule

`default_nettype wire

@@ verif/tb_contiguous_block_allocator_core.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_contiguous_block_allocator_core
// Self-checking bench for the first-fit block allocator. A local copy of the
// usage map predicts status and run start for every accepted request. Results
// are checked in order against that prediction. Directed corner requests come
// first, then a long random mix of allocate, free and mark traffic. Both
// channels idle at random, with two long result hold-offs and two full drains.
// -----------------------------------------------------------------------------

module tb_contiguous_block_allocator_core;
    import cba_pkg::*;

    localparam int NUM_BLK      = 128;
    localparam int N_ITEMS      = 1850;
    localparam int PHASE1_AT    = 620;
    localparam int PHASE2_AT    = 1240;
    localparam int HOLD_CYCLES  = 600;
    localparam int HOLD_AT_A    = 300;
    localparam int HOLD_AT_B    = 1300;
    localparam int DRAIN_AT_A   = 700;
    localparam int DRAIN_AT_B   = 1500;
    localparam int TAIL_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 4000000;

    // the one op code the block ignores
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [LEN_W-1:0]  run_length;
        logic [BLK_W-1:0]  first_block;
        logic [WEND_W-1:0] window_end;
    } t_req_beat;

    typedef struct packed {
        logic      drain;
        t_req_beat beat;
    } t_req_item;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [BLK_W-1:0]  run_start;
    } t_rsp_beat;

    logic i_clk;
    logic i_rst_n;

    cba_req_if req_bus ();
    cba_rsp_if rsp_bus ();

    contiguous_block_allocator_core #(
        .NUM_BLOCKS(NUM_BLK)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    // predicted usage map, superblock taken at reset
    bit [NUM_BLK-1:0] used_map = {{(NUM_BLK-1){1'b0}}, 1'b1};

    t_req_item   req_backlog[$];
    t_rsp_beat   rsp_due_q[$];
    logic        req_fire  = 1'b0;
    int unsigned req_count = 0;
    int unsigned fail_cnt  = 0;
    int unsigned cycle_cnt = 0;
    int unsigned hold_left = 0;
    int unsigned hold_mark = 0;
    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;

    // first-fit search, range update, and the result the block should give
    function automatic t_rsp_beat apply_to_map(t_req_beat rq);
        t_rsp_beat   rs;
        int unsigned wend;
        int unsigned count;
        int unsigned b;
        int unsigned start;
        int unsigned i;
        bit          found;
        rs.status    = ST_DONE;
        rs.run_start = '0;
        found        = 1'b0;
        count        = 0;
        start        = 0;
        if (rq.op == OP_ALLOC) begin
            wend = (rq.window_end > NUM_BLK) ? NUM_BLK : rq.window_end;
            if (rq.run_length != 0) begin
                for (b = rq.first_block; b < wend && !found; b++) begin
                    if (used_map[b]) begin
                        count = 0;
                    end else begin
                        count++;
                        if (count == rq.run_length) begin
                            found = 1'b1;
                            start = b + 1 - rq.run_length;
                        end
                    end
                end
            end
            if (found) begin
                for (i = 0; i < rq.run_length; i++) used_map[start + i] = 1'b1;
                rs.run_start = start[BLK_W-1:0];
            end else begin
                rs.status = ST_NOFIT;
            end
        end else if (rq.op == OP_FREE || rq.op == OP_MARK) begin
            if (int'(rq.first_block) + int'(rq.run_length) > NUM_BLK) begin
                rs.status = ST_RANGE;
            end else begin
                for (i = 0; i < rq.run_length; i++)
                    used_map[rq.first_block + i] = (rq.op == OP_MARK);
            end
        end
        return rs;
    endfunction

    function automatic void push_req(logic [OP_W-1:0] op, int unsigned len,
                                     int unsigned first, int unsigned wend, bit drain);
        t_req_item it;
        it.drain            = drain;
        it.beat.op          = op;
        it.beat.run_length  = len[LEN_W-1:0];
        it.beat.first_block = first[BLK_W-1:0];
        it.beat.window_end  = wend[WEND_W-1:0];
        req_backlog = {req_backlog, it};
    endfunction

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // idle rates per phase: sender light first, then receiver light, then none
    always_comb begin
        if (req_count < PHASE1_AT) begin
            tx_idle_pct = 17;
            rx_idle_pct = 56;
        end else if (req_count < PHASE2_AT) begin
            tx_idle_pct = 56;
            rx_idle_pct = 17;
        end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
    end

    // request driver, holds a beat until it is taken
    always @(negedge i_clk) begin
        t_req_item nxt;
        if (!i_rst_n) begin
            req_bus.valid       <= 1'b0;
            req_bus.op          <= OP_ALLOC;
            req_bus.run_length  <= '0;
            req_bus.first_block <= '0;
            req_bus.window_end  <= '0;
        end else if (!(req_bus.valid && !req_fire)) begin
            if (req_backlog.size() != 0
                    && !(req_backlog[0].drain && rsp_due_q.size() != 0)
                    && $urandom_range(99) >= tx_idle_pct) begin
                nxt = req_backlog.pop_front();
                req_bus.valid       <= 1'b1;
                req_bus.op          <= nxt.beat.op;
                req_bus.run_length  <= nxt.beat.run_length;
                req_bus.first_block <= nxt.beat.first_block;
                req_bus.window_end  <= nxt.beat.window_end;
            end else begin
                req_bus.valid <= 1'b0;
            end
        end
    end

    // result receiver with random stalls and two long hold-offs
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_bus.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            rsp_bus.ready <= 1'b0;
        end else if ((req_count == HOLD_AT_A || req_count == HOLD_AT_B)
                     && hold_mark != req_count) begin
            hold_mark     <= req_count;
            hold_left     <= HOLD_CYCLES;
            rsp_bus.ready <= 1'b0;
        end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // monitor: predict on each request beat, check each result beat
    always @(posedge i_clk) begin
        t_rsp_beat exp_rsp;
        req_fire <= req_bus.valid && req_bus.ready;
        if (i_rst_n && req_bus.valid && req_bus.ready) begin
            rsp_due_q = {rsp_due_q, apply_to_map({req_bus.op, req_bus.run_length,
                                                  req_bus.first_block,
                                                  req_bus.window_end})};
            req_count <= req_count + 1;
        end
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            if (rsp_due_q.size() == 0) begin
                $error("result beat with nothing pending: status %0d run_start %0d",
                       rsp_bus.status, rsp_bus.run_start);
                fail_cnt++;
            end else begin
                exp_rsp = rsp_due_q.pop_front();
                if (rsp_bus.status !== exp_rsp.status) begin
                    $error("status mismatch: expected %0d, got %0d",
                           exp_rsp.status, rsp_bus.status);
                    fail_cnt++;
                end
                if (rsp_bus.run_start !== exp_rsp.run_start) begin
                    $error("run_start mismatch: expected %0d, got %0d",
                           exp_rsp.run_start, rsp_bus.run_start);
                    fail_cnt++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // reset, stimulus and end of run
    initial begin
        int unsigned r;
        int unsigned k;
        int unsigned len;
        int unsigned first;
        int unsigned wend;
        logic [OP_W-1:0] op;

        i_rst_n = 1'b0;

        // directed corners
        push_req(OP_ALLOC, 127, 0, 255, 0);   // longest run, window past the map
        push_req(OP_ALLOC, 1, 0, 128, 0);     // map full
        push_req(OP_FREE, 127, 1, 0, 0);
        push_req(OP_FREE, 0, 0, 0, 0);        // zero-length free
        push_req(OP_MARK, 0, 127, 0, 0);      // zero-length mark
        push_req(OP_ALLOC, 0, 0, 128, 0);     // zero-length allocate
        push_req(OP_ALLOC, 4, 10, 10, 0);     // empty window
        push_req(OP_ALLOC, 4, 127, 200, 0);   // window too short for the run
        push_req(OP_ALLOC, 1, 127, 128, 0);   // last block
        push_req(OP_FREE, 1, 127, 0, 0);
        push_req(OP_FREE, 2, 127, 0, 0);      // range past the last block
        push_req(OP_MARK, 127, 1, 0, 0);      // range ends exactly at the map end
        push_req(OP_MARK, 127, 2, 0, 0);      // range past the last block
        push_req(OP_FREE, 127, 0, 0, 0);      // superblock freed too
        push_req(OP_ALLOC, 1, 0, 1, 0);       // superblock handed out
        push_req(OP_FREE, 1, 0, 0, 0);
        push_req(OP_MARK, 1, 64, 0, 0);
        push_req(OP_ALLOC, 64, 0, 128, 0);
        push_req(OP_ALLOC, 64, 0, 128, 0);    // split free space, no fit
        push_req(OP_UNUSED, 127, 127, 255, 0);
        push_req(OP_UNUSED, 0, 0, 0, 0);
        push_req(OP_FREE, 127, 0, 0, 0);
        push_req(OP_MARK, 1, 0, 0, 0);        // superblock back in use
        push_req(OP_ALLOC, 3, 5, 8, 0);
        push_req(OP_ALLOC, 8, 100, 129, 0);

        // random traffic
        for (k = req_backlog.size(); k < N_ITEMS; k++) begin
            r = $urandom_range(99);
            if (r < 45)
                op = OP_ALLOC;
            else if (r < 75)
                op = OP_FREE;
            else if (r < 98)
                op = OP_MARK;
            else
                op = OP_UNUSED;

            r = $urandom_range(99);
            if (r < 3)
                len = 0;
            else if (r < 70)
                len = $urandom_range(8, 1);
            else if (r < 90)
                len = $urandom_range(32, 9);
            else
                len = $urandom_range(127, 33);

            if (op == OP_ALLOC && $urandom_range(1) == 0)
                first = $urandom_range(15);
            else
                first = $urandom_range(127);

            r = $urandom_range(99);
            if (r < 40)
                wend = NUM_BLK;
            else if (r < 60)
                wend = $urandom_range(255, NUM_BLK + 1);
            else
                wend = $urandom_range(NUM_BLK, 1);

            push_req(op, len, first, wend, (k == DRAIN_AT_A || k == DRAIN_AT_B));
        end

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (req_backlog.size() != 0 || req_bus.valid || rsp_due_q.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_cnt == 0 && rsp_due_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
